[rtl/spb_pkg.sv]
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and codes of the sector port bridge: item field types,
// operation codes, command and status bytes and disk request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spb_pkg;

  // default sector buffer size in bytes
  localparam int unsigned SECTOR_BYTES_DEF = 512;

  // reset value of the control port address
  localparam logic [7:0] CONTROL_PORT_RST = 8'h9E;

  // field types of one word
  typedef logic [2:0] op_t;
  typedef logic [2:0] req_t;

  // operation codes of an input word
  localparam op_t OP_BUS_WR  = 3'd0;
  localparam op_t OP_BUS_RD  = 3'd1;
  localparam op_t OP_DONE    = 3'd2;
  localparam op_t OP_DISK_WR = 3'd3;
  localparam op_t OP_DISK_RD = 3'd4;

  // disk request codes
  localparam req_t RQ_NONE     = 3'd0;
  localparam req_t RQ_INIT     = 3'd1;
  localparam req_t RQ_CAPACITY = 3'd2;
  localparam req_t RQ_READ     = 3'd3;
  localparam req_t RQ_WRITE    = 3'd4;

  // command bytes on the control port
  localparam logic [7:0] CMD_INIT       = 8'h01;
  localparam logic [7:0] CMD_MAKER_ID   = 8'h03;
  localparam logic [7:0] CMD_CAPACITY   = 8'h05;
  localparam logic [7:0] CMD_READ_BLK   = 8'h06;
  localparam logic [7:0] CMD_READ_NEXT  = 8'h07;
  localparam logic [7:0] CMD_WRITE_BLK  = 8'h08;
  localparam logic [7:0] CMD_WRITE_NEXT = 8'h09;

  // status bytes
  localparam logic [7:0] STB_READY   = 8'h00;
  localparam logic [7:0] STB_BUSY    = 8'h01;
  localparam logic [7:0] STB_SENDING = 8'h02;
  localparam logic [7:0] STB_ERROR   = 8'hFF;

  // value of an erased buffer byte
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

`default_nettype wire

[rtl/spb_if.sv]
// ----------------------------------------------------------------------------
// spb_item_if / spb_result_if
// Valid/ready channels of the sector port bridge: one carries a bus or disk
// side access, the other the word returned for it.
// ----------------------------------------------------------------------------
`default_nettype none

interface spb_item_if;
  import spb_pkg::*;

  logic        valid;
  logic        ready;
  op_t         op;
  logic [7:0]  port;
  logic [7:0]  data;
  logic [8:0]  buffer_index;
  logic        disk_ok;
  logic [31:0] disk_value;

  modport source (
    output valid, op, port, data, buffer_index, disk_ok, disk_value,
    input  ready
  );
  modport sink (
    input  valid, op, port, data, buffer_index, disk_ok, disk_value,
    output ready
  );
endinterface

interface spb_result_if;
  import spb_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        read_valid;
  req_t        disk_request;
  logic [31:0] disk_address;

  modport source (
    output valid, read_data, read_valid, disk_request, disk_address,
    input  ready
  );
  modport sink (
    input  valid, read_data, read_valid, disk_request, disk_address,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sector_port_bridge.sv]
// Pipeline: stage 1, stage 2 and the output register, all held by an output stall.
// Throughput: one word per cycle unless an output stall or the clearing sweep
// holds it; the sector buffer RAM port is used at most once per word.
// Reset: control state clears at once, then a sweep writes 0xFF through the buffer;
// item.ready stays low during the sweep.
// ----------------------------------------------------------------------------
// sector_port_bridge
// Bus bridge to a sector store: command/status port, data port streaming a
// sector buffer, disk requests with completions and disk side buffer access.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_port_bridge #(
  parameter int unsigned SECTOR_BYTES = spb_pkg::SECTOR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  spb_item_if.sink     item,
  spb_result_if.source result
);
  import spb_pkg::*;

  localparam int unsigned AW = $clog2(SECTOR_BYTES);
  localparam int unsigned PW = $clog2(SECTOR_BYTES + 1);
  localparam logic [PW-1:0] SB_CNT = PW'(SECTOR_BYTES);
  localparam logic [AW-1:0] SB_LAST = AW'(SECTOR_BYTES - 1);

  typedef enum logic [1:0] {
    ST_READY,
    ST_BUSY,
    ST_SENDING,
    ST_ERROR
  } status_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        use_ram;
    logic        rvalid;
    req_t        req;
    logic [31:0] addr;
  } stage_res_t;

  // configuration
  logic [7:0] control_port;
  logic [7:0] data_port;

  // clearing sweep
  logic          clr_busy;
  logic [AW-1:0] clr_cnt;

  // pipeline control
  logic adv;
  logic commit;

  // stage 1: accepted word
  logic        s1_valid;
  op_t         s1_op;
  logic [7:0]  s1_port;
  logic [7:0]  s1_data;
  logic [8:0]  s1_bidx;
  logic        s1_ok;
  logic [31:0] s1_value;

  // stage 2 and output register
  logic        s2_valid;
  stage_res_t  s2;
  stage_res_t  s2_next;
  logic        res_valid;
  logic [7:0]  res_rdata;
  logic        res_rvalid;
  req_t        res_req;
  logic [31:0] res_addr;

  // bridge state
  status_t       status, status_next;
  logic [PW-1:0] to_send, to_send_next;
  logic [PW-1:0] to_recv, to_recv_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [31:0]   sec_addr, sec_addr_next;
  logic          addr_phase, addr_phase_next;
  logic          card_ready, card_ready_next;
  logic [7:0]    maker_id, maker_id_next;
  req_t          awaited, awaited_next;
  logic [7:0]    shadow [4];
  logic [7:0]    shadow_next [4];

  // buffer RAM port
  logic          s1_we;
  logic [AW-1:0] s1_waddr;
  logic [7:0]    s1_wdata;
  logic          s1_re;
  logic [AW-1:0] s1_raddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // stage 1 helpers
  logic          busy;
  logic [AW-1:0] pos_idx;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] recv_dec;
  logic [PW-1:0] send_dec;
  logic          needs_card;
  logic          bidx_ok;
  logic [AW-1:0] bidx_a;
  logic [7:0]    status_byte;

  assign data_port = control_port + 8'd1;
  assign adv       = !res_valid || result.ready;
  assign item.ready = adv && !clr_busy;
  assign commit    = s1_valid && adv;

  // control port register
  always_ff @(posedge clk) begin
    if (rst) begin
      control_port <= CONTROL_PORT_RST;
    end else if (cfg_wr_en) begin
      control_port <= cfg_wr_data;
    end
  end

  // buffer clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == SB_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // status byte of the current status code
  always_comb begin
    case (status)
      ST_READY:   status_byte = STB_READY;
      ST_BUSY:    status_byte = STB_BUSY;
      ST_SENDING: status_byte = STB_SENDING;
      ST_ERROR:   status_byte = STB_ERROR;
      default:    status_byte = STB_ERROR;
    endcase
  end

  // stage 1 helpers
  assign busy     = (awaited != RQ_NONE);
  assign pos_idx  = (byte_pos < SB_CNT) ? byte_pos[AW-1:0] : '0;
  assign pos_inc  = PW'(pos_idx) + PW'(1);
  assign recv_dec = to_recv - PW'(1);
  assign send_dec = to_send - PW'(1);
  assign bidx_ok  = PW'(s1_bidx) < SB_CNT;
  assign bidx_a   = AW'(s1_bidx);
  assign needs_card = (s1_data == CMD_MAKER_ID) || (s1_data == CMD_CAPACITY) ||
                      (s1_data == CMD_READ_BLK) || (s1_data == CMD_READ_NEXT) ||
                      (s1_data == CMD_WRITE_BLK) || (s1_data == CMD_WRITE_NEXT);

  // single pass over the word in stage 1
  always_comb begin
    status_next     = status;
    to_send_next    = to_send;
    to_recv_next    = to_recv;
    byte_pos_next   = byte_pos;
    sec_addr_next   = sec_addr;
    addr_phase_next = addr_phase;
    card_ready_next = card_ready;
    maker_id_next   = maker_id;
    awaited_next    = awaited;
    shadow_next     = shadow;
    s1_we    = 1'b0;
    s1_waddr = pos_idx;
    s1_wdata = s1_data;
    s1_re    = 1'b0;
    s1_raddr = pos_idx;
    s2_next  = '0;

    if (commit) begin
      case (s1_op)
        OP_BUS_WR: begin
          if (!busy) begin
            if (s1_port == control_port) begin
              if (needs_card && !card_ready) begin
                status_next = ST_ERROR;
              end else begin
                case (s1_data)
                  CMD_INIT: begin
                    status_next  = ST_BUSY;
                    awaited_next = RQ_INIT;
                    s2_next.req  = RQ_INIT;
                  end
                  CMD_MAKER_ID: begin
                    shadow_next[0] = maker_id;
                    to_send_next   = PW'(1);
                    byte_pos_next  = '0;
                    status_next    = ST_READY;
                  end
                  CMD_CAPACITY: begin
                    status_next  = ST_BUSY;
                    awaited_next = RQ_CAPACITY;
                    s2_next.req  = RQ_CAPACITY;
                  end
                  CMD_READ_BLK: begin
                    if (!addr_phase) begin
                      to_recv_next    = PW'(4);
                      byte_pos_next   = '0;
                      status_next     = ST_BUSY;
                      addr_phase_next = 1'b1;
                    end else begin
                      sec_addr_next   = {shadow[3], shadow[2], shadow[1], shadow[0]};
                      addr_phase_next = 1'b0;
                      status_next     = ST_BUSY;
                      awaited_next    = RQ_READ;
                      s2_next.req     = RQ_READ;
                    end
                  end
                  CMD_READ_NEXT: begin
                    sec_addr_next = sec_addr + 32'd1;
                    status_next   = ST_BUSY;
                    awaited_next  = RQ_READ;
                    s2_next.req   = RQ_READ;
                  end
                  CMD_WRITE_BLK: begin
                    if (!addr_phase) begin
                      to_recv_next    = PW'(4);
                      byte_pos_next   = '0;
                      status_next     = ST_BUSY;
                      addr_phase_next = 1'b1;
                    end else begin
                      sec_addr_next   = {shadow[3], shadow[2], shadow[1], shadow[0]};
                      addr_phase_next = 1'b0;
                      to_recv_next    = SB_CNT;
                      byte_pos_next   = '0;
                      status_next     = ST_BUSY;
                    end
                  end
                  CMD_WRITE_NEXT: begin
                    sec_addr_next   = sec_addr + 32'd1;
                    addr_phase_next = 1'b0;
                    to_recv_next    = SB_CNT;
                    byte_pos_next   = '0;
                    status_next     = ST_BUSY;
                  end
                  default: begin
                  end
                endcase
              end
            end else if (s1_port == data_port && to_recv != '0) begin
              // streamed byte into the buffer
              s1_we    = 1'b1;
              s1_waddr = pos_idx;
              if (pos_idx[AW-1:2] == '0) begin
                shadow_next[pos_idx[1:0]] = s1_data;
              end
              byte_pos_next = pos_inc;
              to_recv_next  = recv_dec;
              // last payload byte launches the sector write
              if (!addr_phase && recv_dec == '0 && pos_inc >= SB_CNT) begin
                byte_pos_next = '0;
                status_next   = ST_BUSY;
                awaited_next  = RQ_WRITE;
                s2_next.req   = RQ_WRITE;
              end
            end
          end
        end
        OP_BUS_RD: begin
          if (s1_port == control_port) begin
            s2_next.rdata  = status_byte;
            s2_next.rvalid = 1'b1;
          end else if (s1_port == data_port && !busy && to_send != '0) begin
            s2_next.rvalid = 1'b1;
            if (pos_idx[AW-1:2] == '0) begin
              s2_next.rdata = shadow[pos_idx[1:0]];
            end else begin
              s1_re           = 1'b1;
              s1_raddr        = pos_idx;
              s2_next.use_ram = 1'b1;
            end
            byte_pos_next = pos_inc;
            to_send_next  = send_dec;
            status_next   = (send_dec == '0) ? ST_READY : ST_SENDING;
          end
        end
        OP_DONE: begin
          awaited_next = RQ_NONE;
          case (awaited)
            RQ_INIT: begin
              card_ready_next = s1_ok;
              if (s1_ok) begin
                maker_id_next = s1_value[7:0];
              end
              status_next = s1_ok ? ST_READY : ST_ERROR;
            end
            RQ_CAPACITY: begin
              if (s1_ok) begin
                shadow_next[0] = s1_value[7:0];
                shadow_next[1] = s1_value[15:8];
                shadow_next[2] = s1_value[23:16];
                shadow_next[3] = s1_value[31:24];
                to_send_next   = PW'(4);
                byte_pos_next  = '0;
                status_next    = ST_READY;
              end else begin
                to_send_next = '0;
                status_next  = ST_ERROR;
              end
            end
            RQ_READ: begin
              if (s1_ok) begin
                to_send_next  = SB_CNT;
                byte_pos_next = '0;
                status_next   = ST_SENDING;
              end else begin
                to_send_next = '0;
                status_next  = ST_ERROR;
              end
            end
            RQ_WRITE: begin
              status_next = s1_ok ? ST_READY : ST_ERROR;
            end
            default: begin
              // stray completion
              awaited_next = awaited;
            end
          endcase
        end
        OP_DISK_WR: begin
          if (bidx_ok) begin
            s1_we    = 1'b1;
            s1_waddr = bidx_a;
            if (bidx_a[AW-1:2] == '0) begin
              shadow_next[bidx_a[1:0]] = s1_data;
            end
          end
        end
        OP_DISK_RD: begin
          s2_next.rvalid = 1'b1;
          if (!bidx_ok) begin
            s2_next.rdata = ERASED_BYTE;
          end else if (bidx_a[AW-1:2] == '0) begin
            s2_next.rdata = shadow[bidx_a[1:0]];
          end else begin
            s1_re           = 1'b1;
            s1_raddr        = bidx_a;
            s2_next.use_ram = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (s2_next.req == RQ_READ || s2_next.req == RQ_WRITE) begin
        s2_next.addr = sec_addr_next;
      end
    end
  end

  // bridge state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status     <= ST_READY;
      to_send    <= '0;
      to_recv    <= '0;
      byte_pos   <= '0;
      sec_addr   <= '0;
      addr_phase <= 1'b0;
      card_ready <= 1'b0;
      maker_id   <= '0;
      awaited    <= RQ_NONE;
      shadow     <= '{default: ERASED_BYTE};
    end else begin
      status     <= status_next;
      to_send    <= to_send_next;
      to_recv    <= to_recv_next;
      byte_pos   <= byte_pos_next;
      sec_addr   <= sec_addr_next;
      addr_phase <= addr_phase_next;
      card_ready <= card_ready_next;
      maker_id   <= maker_id_next;
      awaited    <= awaited_next;
      shadow     <= shadow_next;
    end
  end

  // buffer RAM write port shared with the clearing sweep
  assign ram_we    = clr_busy || s1_we;
  assign ram_waddr = clr_busy ? clr_cnt : s1_waddr;
  assign ram_wdata = clr_busy ? ERASED_BYTE : s1_wdata;

  spb_ram #(
    .WIDTH (8),
    .DEPTH (SECTOR_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_re),
    .raddr (s1_raddr),
    .rdata (ram_rdata)
  );

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= item.valid && item.ready;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op      <= item.op;
      s1_port    <= item.port;
      s1_data    <= item.data;
      s1_bidx    <= item.buffer_index;
      s1_ok      <= item.disk_ok;
      s1_value   <= item.disk_value;
      s2         <= s2_next;
      res_rdata  <= s2.use_ram ? ram_rdata : s2.rdata;
      res_rvalid <= s2.rvalid;
      res_req    <= s2.req;
      res_addr   <= s2.addr;
    end
  end

  // result word
  assign result.valid        = res_valid;
  assign result.read_data    = res_rdata;
  assign result.read_valid   = res_rvalid;
  assign result.disk_request = res_req;
  assign result.disk_address = res_addr;

  // no new word enters while the buffer is being cleared
  a_clr_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !item.ready)
    else $error("word accepted during buffer clearing");

  // a request in flight is still awaited by the bridge
  a_req_awaited: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2.req != RQ_NONE) |-> (awaited != RQ_NONE))
    else $error("issued request not recorded as awaited");

  // stream counters stay within one sector
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (byte_pos <= SB_CNT) && (to_send <= SB_CNT) && (to_recv <= SB_CNT))
    else $error("stream counter beyond sector size");

  // an undriven read carries zero data
  a_undriven_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.read_valid) |-> (result.read_data == 8'h00))
    else $error("data on an undriven read");

endmodule

`default_nettype wire

[rtl/spb_ram.sv]
// ----------------------------------------------------------------------------
// spb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
